// ----- src/soa_pkg.sv -----
package soa_pkg;

  // request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_ALLOC_EMPTY = 3'd0;
  localparam logic [2:0] KIND_ALLOC_PART  = 3'd1;
  localparam logic [2:0] KIND_FREE_FULL   = 3'd2;
  localparam logic [2:0] KIND_FREE_PART   = 3'd3;
  localparam logic [2:0] KIND_NONE        = 3'd4;
  localparam logic [2:0] KIND_SUMMARY     = 3'd5;

  // list moves
  localparam logic [2:0] MOVE_NONE          = 3'd0;
  localparam logic [2:0] MOVE_EMPTY_TO_PART = 3'd1;
  localparam logic [2:0] MOVE_PART_TO_FULL  = 3'd2;
  localparam logic [2:0] MOVE_FULL_TO_PART  = 3'd3;
  localparam logic [2:0] MOVE_PART_TO_EMPTY = 3'd4;

  // summary status
  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_CAPACITY   = 3'd1;
  localparam logic [2:0] STATUS_NOT_ENOUGH = 3'd2;
  localparam logic [2:0] STATUS_NO_CACHE   = 3'd3;
  localparam logic [2:0] STATUS_TABLE_FULL = 3'd4;

  // register map
  localparam logic REG_FIRST_OBJ = 1'b0;

  localparam logic [7:0] FIRST_OBJ_RESET = 8'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CREATE,
    ST_CHECK,
    ST_STEP,
    ST_SUM
  } soa_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] move;
    logic [7:0] fill;
  } step_res_t;

  typedef struct packed {
    logic init;   // re-initialise entry with a new key
    logic cnt;    // write object total
    logic slab;   // write slab lists
  } tbl_wr_t;

endpackage

// ----- src/slab_object_accounting.sv -----
// Channel  | direction | transfer when          | payload
// in_      | in        | in_valid & !in_stall   | func, obj_per_slab, count
// out_     | out       | out_valid & !out_stall | kind, move, slab_fill, status,
//          |           |                        | cache_total, last
// cfg (APB)| in        | psel&penable&pwrite    | reg 0 first_cache_objects @0x0
//
// Per request: accept, scan (one table entry per cycle, stops on the first
// key match, up to MAX_CACHES), create (new cache only), check, one object
// step per counted object unless the check fails, summary. The single-entry
// table port and the shared step unit give one object per unstalled cycle.
// Reset: synchronous, active low; entry zero comes up valid with key 5.
// A stalled output holds the sequencer in its step or summary state;
// in_stall is high for the whole request.
module slab_object_accounting #(
  parameter int SLABS_PER_CACHE = 5,
  parameter int MAX_CACHES      = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_obj_per_slab,
  input  logic [5:0]  in_count,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_move,
  output logic [7:0]  out_slab_fill,
  output logic [2:0]  out_status,
  output logic [10:0] out_cache_total,
  output logic        out_last,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W  = (MAX_CACHES > 1) ? $clog2(MAX_CACHES) : 1;
  localparam int SLAB_W = $clog2(SLABS_PER_CACHE + 1);
  // object total can reach 255 objects times the slab count
  localparam int CNT_W  = $clog2(255 * SLABS_PER_CACHE + 1);

  logic [7:0]        first_obj_r;
  logic              cfg_wr;
  logic              cfg_wr0;

  logic [IDX_W-1:0]  seq_idx;
  soa_pkg::tbl_wr_t  seq_wr;
  logic [7:0]        seq_key;
  soa_pkg::tbl_wr_t  tbl_wr;
  logic [IDX_W-1:0]  tbl_idx;
  logic [7:0]        tbl_key;
  logic [CNT_W-1:0]  wr_count;
  logic [SLAB_W-1:0] wr_full;
  logic [7:0]        wr_pfill;
  logic [SLAB_W-1:0] wr_empty;
  logic              rd_valid;
  logic [7:0]        rd_key;
  logic [CNT_W-1:0]  rd_count;
  logic [SLAB_W-1:0] rd_full;
  logic [7:0]        rd_pfill;
  logic [SLAB_W-1:0] rd_empty;
  logic [CNT_W-1:0]  out_total;

  // config port: zero wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_wr0 = cfg_wr && (paddr[2] == soa_pkg::REG_FIRST_OBJ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_obj_r <= soa_pkg::FIRST_OBJ_RESET;
    end else if (cfg_wr0) begin
      first_obj_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == soa_pkg::REG_FIRST_OBJ) ? {24'd0, first_obj_r} : 32'd0;

  // a config write re-creates entry zero; user writes only while idle (unchecked)
  always_comb begin
    tbl_wr      = seq_wr;
    tbl_idx     = seq_idx;
    tbl_key     = seq_key;
    if (cfg_wr0) begin
      tbl_wr.init = 1'b1;
      tbl_idx     = '0;
      tbl_key     = pwdata[7:0];
    end
  end

  soa_table #(
    .SPC    (SLABS_PER_CACHE),
    .MAXC   (MAX_CACHES),
    .IDX_W  (IDX_W),
    .SLAB_W (SLAB_W),
    .CNT_W  (CNT_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .idx      (tbl_idx),
    .wr       (tbl_wr),
    .init_key (tbl_key),
    .wr_count (wr_count),
    .wr_full  (wr_full),
    .wr_pfill (wr_pfill),
    .wr_empty (wr_empty),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_count (rd_count),
    .rd_full  (rd_full),
    .rd_pfill (rd_pfill),
    .rd_empty (rd_empty)
  );

  soa_seq #(
    .SPC    (SLABS_PER_CACHE),
    .MAXC   (MAX_CACHES),
    .IDX_W  (IDX_W),
    .SLAB_W (SLAB_W),
    .CNT_W  (CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_key     (in_obj_per_slab),
    .in_count   (in_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_move   (out_move),
    .out_fill   (out_slab_fill),
    .out_status (out_status),
    .out_total  (out_total),
    .out_last   (out_last),
    .tbl_idx    (seq_idx),
    .tbl_wr     (seq_wr),
    .tbl_key    (seq_key),
    .wr_count   (wr_count),
    .wr_full    (wr_full),
    .wr_pfill   (wr_pfill),
    .wr_empty   (wr_empty),
    .rd_valid   (rd_valid),
    .rd_key     (rd_key),
    .rd_count   (rd_count),
    .rd_full    (rd_full),
    .rd_pfill   (rd_pfill),
    .rd_empty   (rd_empty)
  );

  // reported total is 11 bits wide
  assign out_cache_total = 11'(out_total);

endmodule

// ----- src/soa_step.sv -----
// One object step on a cache entry: allocate or free a single object.
module soa_step #(
  parameter int SLAB_W = 3
) (
  input  logic              func,
  input  logic [7:0]        key,
  input  logic [7:0]        pfill,
  input  logic [SLAB_W-1:0] full,
  input  logic [SLAB_W-1:0] empty,
  output soa_pkg::step_res_t res,
  output logic [7:0]        pfill_nxt,
  output logic [SLAB_W-1:0] full_nxt,
  output logic [SLAB_W-1:0] empty_nxt
);

  logic [8:0] inc;
  logic [7:0] dec;
  logic [7:0] key_m1;

  assign inc    = {1'b0, pfill} + 9'd1;
  assign dec    = pfill - 8'd1;
  assign key_m1 = (key != 8'd0) ? key - 8'd1 : 8'd0;

  always_comb begin
    res.kind  = soa_pkg::KIND_NONE;
    res.move  = soa_pkg::MOVE_NONE;
    res.fill  = 8'd0;
    pfill_nxt = pfill;
    full_nxt  = full;
    empty_nxt = empty;
    if (func == soa_pkg::FUNC_ALLOC) begin
      if (pfill != 8'd0) begin
        res.kind = soa_pkg::KIND_ALLOC_PART;
        res.fill = inc[7:0];
        if (inc >= {1'b0, key}) begin
          full_nxt  = full + SLAB_W'(1);
          pfill_nxt = 8'd0;
          res.move  = soa_pkg::MOVE_PART_TO_FULL;
        end else begin
          pfill_nxt = inc[7:0];
        end
      end else if (empty != '0) begin
        empty_nxt = empty - SLAB_W'(1);
        res.kind  = soa_pkg::KIND_ALLOC_EMPTY;
        res.fill  = 8'd1;
        if (key <= 8'd1) begin
          // single-object slab is full straight away
          full_nxt = full + SLAB_W'(1);
          res.move = soa_pkg::MOVE_PART_TO_FULL;
        end else begin
          pfill_nxt = 8'd1;
          res.move  = soa_pkg::MOVE_EMPTY_TO_PART;
        end
      end
    end else begin
      if (pfill != 8'd0) begin
        res.kind  = soa_pkg::KIND_FREE_PART;
        res.fill  = dec;
        pfill_nxt = dec;
        if (dec == 8'd0) begin
          empty_nxt = empty + SLAB_W'(1);
          res.move  = soa_pkg::MOVE_PART_TO_EMPTY;
        end
      end else if (full != '0) begin
        full_nxt = full - SLAB_W'(1);
        res.kind = soa_pkg::KIND_FREE_FULL;
        res.fill = key_m1;
        if (key_m1 == 8'd0) begin
          empty_nxt = empty + SLAB_W'(1);
          res.move  = soa_pkg::MOVE_PART_TO_EMPTY;
        end else begin
          pfill_nxt = key_m1;
          res.move  = soa_pkg::MOVE_FULL_TO_PART;
        end
      end
    end
  end

endmodule

// ----- src/soa_table.sv -----
// Per-cache accounting entries, one read/write index.
module soa_table #(
  parameter int SPC    = 5,
  parameter int MAXC   = 8,
  parameter int IDX_W  = 3,
  parameter int SLAB_W = 3,
  parameter int CNT_W  = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  idx,
  input  soa_pkg::tbl_wr_t  wr,
  input  logic [7:0]        init_key,
  input  logic [CNT_W-1:0]  wr_count,
  input  logic [SLAB_W-1:0] wr_full,
  input  logic [7:0]        wr_pfill,
  input  logic [SLAB_W-1:0] wr_empty,
  output logic              rd_valid,
  output logic [7:0]        rd_key,
  output logic [CNT_W-1:0]  rd_count,
  output logic [SLAB_W-1:0] rd_full,
  output logic [7:0]        rd_pfill,
  output logic [SLAB_W-1:0] rd_empty
);

  logic [MAXC-1:0]   valid_r;
  logic [7:0]        key_r   [MAXC];
  logic [CNT_W-1:0]  count_r [MAXC];
  logic [SLAB_W-1:0] full_r  [MAXC];
  logic [7:0]        pfill_r [MAXC];
  logic [SLAB_W-1:0] empty_r [MAXC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= MAXC'(1);
      key_r[0]   <= soa_pkg::FIRST_OBJ_RESET;
      count_r[0] <= '0;
      full_r[0]  <= '0;
      pfill_r[0] <= 8'd0;
      empty_r[0] <= SLAB_W'(SPC);
    end else begin
      if (wr.init) begin
        valid_r[idx] <= 1'b1;
        key_r[idx]   <= init_key;
        count_r[idx] <= '0;
        full_r[idx]  <= '0;
        pfill_r[idx] <= 8'd0;
        empty_r[idx] <= SLAB_W'(SPC);
      end
      if (wr.cnt) begin
        count_r[idx] <= wr_count;
      end
      if (wr.slab) begin
        full_r[idx]  <= wr_full;
        pfill_r[idx] <= wr_pfill;
        empty_r[idx] <= wr_empty;
      end
    end
  end

  assign rd_valid = valid_r[idx];
  assign rd_key   = key_r[idx];
  assign rd_count = count_r[idx];
  assign rd_full  = full_r[idx];
  assign rd_pfill = pfill_r[idx];
  assign rd_empty = empty_r[idx];

endmodule

// ----- src/soa_seq.sv -----
// Request sequencer: table scan, cache creation, capacity or count check, object steps, summary.
module soa_seq #(
  parameter int SPC    = 5,
  parameter int MAXC   = 8,
  parameter int IDX_W  = 3,
  parameter int SLAB_W = 3,
  parameter int CNT_W  = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [7:0]        in_key,
  input  logic [5:0]        in_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_kind,
  output logic [2:0]        out_move,
  output logic [7:0]        out_fill,
  output logic [2:0]        out_status,
  output logic [CNT_W-1:0]  out_total,
  output logic              out_last,
  output logic [IDX_W-1:0]  tbl_idx,
  output soa_pkg::tbl_wr_t  tbl_wr,
  output logic [7:0]        tbl_key,
  output logic [CNT_W-1:0]  wr_count,
  output logic [SLAB_W-1:0] wr_full,
  output logic [7:0]        wr_pfill,
  output logic [SLAB_W-1:0] wr_empty,
  input  logic              rd_valid,
  input  logic [7:0]        rd_key,
  input  logic [CNT_W-1:0]  rd_count,
  input  logic [SLAB_W-1:0] rd_full,
  input  logic [7:0]        rd_pfill,
  input  logic [SLAB_W-1:0] rd_empty
);

  soa_pkg::soa_state_t state_r, state_nxt;

  logic              func_r, func_nxt;
  logic [7:0]        key_r, key_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [5:0]        rem_r, rem_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;

  logic              ov_r, ov_nxt;
  logic [2:0]        okind_r, okind_nxt;
  logic [2:0]        omove_r, omove_nxt;
  logic [7:0]        ofill_r, ofill_nxt;
  logic [2:0]        ostat_r, ostat_nxt;
  logic [CNT_W-1:0]  ototal_r, ototal_nxt;
  logic              olast_r, olast_nxt;

  logic              out_free;
  logic              hit;
  logic              last_idx;
  logic              is_alloc;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W:0]    sum_a;
  logic              over;
  logic              short;
  logic              check_fail;
  logic [CNT_W-1:0]  new_count;

  soa_pkg::step_res_t step_res;
  logic [7:0]        step_pfill;
  logic [SLAB_W-1:0] step_full;
  logic [SLAB_W-1:0] step_empty;

  soa_step #(.SLAB_W(SLAB_W)) u_step (
    .func      (func_r),
    .key       (rd_key),
    .pfill     (rd_pfill),
    .full      (rd_full),
    .empty     (rd_empty),
    .res       (step_res),
    .pfill_nxt (step_pfill),
    .full_nxt  (step_full),
    .empty_nxt (step_empty)
  );

  assign out_free   = !ov_r || !out_stall;
  assign hit        = rd_valid && (rd_key == key_r);
  assign last_idx   = (idx_r == IDX_W'(MAXC - 1));
  assign is_alloc   = (func_r == soa_pkg::FUNC_ALLOC);
  assign cap        = CNT_W'(key_r) * CNT_W'(SPC);
  assign sum_a      = {1'b0, rd_count} + (CNT_W + 1)'(cnt_r);
  assign over       = sum_a > {1'b0, cap};
  assign short      = CNT_W'(cnt_r) > rd_count;
  assign check_fail = is_alloc ? over : short;
  assign new_count  = is_alloc ? sum_a[CNT_W-1:0] : rd_count - CNT_W'(cnt_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      soa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = soa_pkg::ST_SCAN;
      end
      soa_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = soa_pkg::ST_CHECK;
        end else if (last_idx) begin
          if (is_alloc && (free_found_r || !rd_valid)) state_nxt = soa_pkg::ST_CREATE;
          else state_nxt = soa_pkg::ST_SUM;
        end
      end
      soa_pkg::ST_CREATE: state_nxt = soa_pkg::ST_CHECK;
      soa_pkg::ST_CHECK: begin
        if (check_fail || cnt_r == 6'd0) state_nxt = soa_pkg::ST_SUM;
        else state_nxt = soa_pkg::ST_STEP;
      end
      soa_pkg::ST_STEP: begin
        if (out_free && rem_r == 6'd1) state_nxt = soa_pkg::ST_SUM;
      end
      soa_pkg::ST_SUM: begin
        if (out_free) state_nxt = soa_pkg::ST_IDLE;
      end
      default: state_nxt = soa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != soa_pkg::ST_IDLE);
    tbl_wr         = '0;
    wr_count       = new_count;
    wr_full        = step_full;
    wr_pfill       = step_pfill;
    wr_empty       = step_empty;
    func_nxt       = func_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    idx_nxt        = idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    status_nxt     = status_r;
    total_nxt      = total_r;
    ov_nxt         = ov_r && out_stall;
    okind_nxt      = okind_r;
    omove_nxt      = omove_r;
    ofill_nxt      = ofill_r;
    ostat_nxt      = ostat_r;
    ototal_nxt     = ototal_r;
    olast_nxt      = olast_r;

    unique case (state_r)
      soa_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt       = in_func;
          key_nxt        = in_key;
          cnt_nxt        = in_count;
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
        end
      end
      soa_pkg::ST_SCAN: begin
        if (!hit) begin
          if (!rd_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          if (last_idx) begin
            if (is_alloc && (free_found_r || !rd_valid)) begin
              idx_nxt = free_found_r ? free_idx_r : idx_r;
            end else begin
              status_nxt = is_alloc ? soa_pkg::STATUS_TABLE_FULL : soa_pkg::STATUS_NO_CACHE;
              total_nxt  = '0;
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      soa_pkg::ST_CREATE: begin
        tbl_wr.init = 1'b1;
      end
      soa_pkg::ST_CHECK: begin
        if (check_fail) begin
          status_nxt = is_alloc ? soa_pkg::STATUS_CAPACITY : soa_pkg::STATUS_NOT_ENOUGH;
          total_nxt  = rd_count;
        end else begin
          tbl_wr.cnt = 1'b1;
          status_nxt = soa_pkg::STATUS_OK;
          total_nxt  = new_count;
          rem_nxt    = cnt_r;
        end
      end
      soa_pkg::ST_STEP: begin
        if (out_free) begin
          tbl_wr.slab = 1'b1;
          rem_nxt     = rem_r - 6'd1;
          ov_nxt      = 1'b1;
          okind_nxt   = step_res.kind;
          omove_nxt   = step_res.move;
          ofill_nxt   = step_res.fill;
          ostat_nxt   = soa_pkg::STATUS_OK;
          ototal_nxt  = total_r;
          olast_nxt   = 1'b0;
        end
      end
      soa_pkg::ST_SUM: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = soa_pkg::KIND_SUMMARY;
          omove_nxt  = soa_pkg::MOVE_NONE;
          ofill_nxt  = 8'd0;
          ostat_nxt  = status_r;
          ototal_nxt = total_r;
          olast_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= soa_pkg::ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    cnt_r        <= cnt_nxt;
    rem_r        <= rem_nxt;
    idx_r        <= idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    status_r     <= status_nxt;
    total_r      <= total_nxt;
    okind_r      <= okind_nxt;
    omove_r      <= omove_nxt;
    ofill_r      <= ofill_nxt;
    ostat_r      <= ostat_nxt;
    ototal_r     <= ototal_nxt;
    olast_r      <= olast_nxt;
  end

  assign tbl_idx    = idx_r;
  assign tbl_key    = key_r;
  assign out_valid  = ov_r;
  assign out_kind   = okind_r;
  assign out_move   = omove_r;
  assign out_fill   = ofill_r;
  assign out_status = ostat_r;
  assign out_total  = ototal_r;
  assign out_last   = olast_r;

endmodule
